FILE: src/ladp_pkg.sv
// Shared types and constants of the latency aware delta prefetcher.
// Used by every module in src; no dependencies.
package ladp_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int OFFSET_SLOTS  = 16;
  localparam int DELTA_SLOTS   = 8;
  localparam int MISS_INTERVAL = 1024;
  localparam int PENDING_DEPTH = 32;

  localparam int ADDR_W   = 48;
  localparam int LINE_W   = ADDR_W - 6;
  localparam int SEL_W    = 6;
  localparam int STAMP_W  = 16;
  localparam int TAB_W    = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W   = $clog2(OFFSET_SLOTS);
  localparam int DSLOT_W  = $clog2(DELTA_SLOTS);
  localparam int PEND_W   = $clog2(PENDING_DEPTH + 1);
  localparam int PIDX_W   = $clog2(PENDING_DEPTH);
  localparam int MCNT_W   = $clog2(MISS_INTERVAL + 1);
  localparam int MISS_SHIFT = $clog2(MISS_INTERVAL);

  localparam logic [1:0] CMD_ACCESS = 2'd0;
  localparam logic [1:0] CMD_FILL   = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [2:0] CONF_MAX    = 3'd7;
  localparam logic [2:0] CONF_THRESH = 3'd4;
  localparam logic [15:0] DELAY_ADD  = 16'd50;
  localparam logic [15:0] DELAY_SAT  = 16'hFFFF;

  typedef struct packed {
    logic [7:0]                                tag;
    logic [OFFSET_SLOTS-1:0][7:0]              offsets;
    logic [OFFSET_SLOTS-1:0][STAMP_W-1:0]      stamps;
    logic [SLOT_W-1:0]                         write_slot;
    logic [DELTA_SLOTS-1:0][8:0]               deltas;
    logic [DELTA_SLOTS-1:0][2:0]               confs;
    logic [8:0]                                top_delta;
  } entry_t;

  // search results handed from the first to the second update stage
  typedef struct packed {
    logic               same_page;
    logic               no_change;
    logic               found;
    logic [8:0]         delta;
    logic [2:0]         peak_conf;
    logic [DSLOT_W-1:0] max_idx;
  } search_t;

endpackage

FILE: src/ladp_miss_track.sv
// Pending miss set, latency accumulation and average delay tracking.
// Depends on ladp_pkg.
module ladp_miss_track (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          req_i,
  input  logic [1:0]                    cmd_i,
  input  logic                          was_hit_i,
  input  logic [ladp_pkg::LINE_W-1:0]   line_i,
  output logic [15:0]                   mean_wait_o
);

  logic [ladp_pkg::PENDING_DEPTH-1:0]                       valid_q, valid_d;
  logic [ladp_pkg::PENDING_DEPTH-1:0][ladp_pkg::LINE_W-1:0] lines_q;
  logic [ladp_pkg::PEND_W-1:0] count_q, count_d;
  logic [ladp_pkg::MCNT_W-1:0] miss_q, miss_d;
  logic [31:0]                 sum_q, sum_d;
  logic [15:0]                 avg_q, avg_d;

  logic [ladp_pkg::PENDING_DEPTH-1:0] match;
  logic                        any_match, have_free;
  logic [ladp_pkg::PIDX_W-1:0] free_idx, match_idx;
  logic                        ins;
  logic [32:0]                 sum_ext;
  logic [22:0]                 avg_ext;

  always_comb begin
    any_match = 1'b0;
    have_free = 1'b0;
    free_idx  = '0;
    match_idx = '0;
    for (int i = ladp_pkg::PENDING_DEPTH - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (lines_q[i] == line_i);
      if (match[i]) begin
        any_match = 1'b1;
        match_idx = ladp_pkg::PIDX_W'(i);
      end
      if (!valid_q[i]) begin
        have_free = 1'b1;
        free_idx  = ladp_pkg::PIDX_W'(i);
      end
    end
  end

  assign sum_ext = {1'b0, sum_q} + 33'(count_q);
  assign avg_ext = 23'(sum_q >> ladp_pkg::MISS_SHIFT) + 23'(ladp_pkg::DELAY_ADD);
  assign ins = req_i && (cmd_i == ladp_pkg::CMD_ACCESS) && !was_hit_i
               && !any_match && have_free;

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    miss_d  = miss_q;
    sum_d   = sum_q;
    avg_d   = avg_q;
    if (cfg_we_i) begin
      avg_d = cfg_data_i;
    end
    if (ins) begin
      valid_d[free_idx] = 1'b1;
      count_d = count_q + 1'b1;
      if (miss_q + 1'b1 >= ladp_pkg::MCNT_W'(ladp_pkg::MISS_INTERVAL)) begin
        miss_d = '0;
        sum_d  = '0;
        avg_d  = (avg_ext > 23'(ladp_pkg::DELAY_SAT)) ? ladp_pkg::DELAY_SAT : avg_ext[15:0];
      end else begin
        miss_d = miss_q + 1'b1;
      end
    end else if (req_i && cmd_i == ladp_pkg::CMD_FILL && any_match) begin
      valid_d[match_idx] = 1'b0;
      count_d = count_q - 1'b1;
    end else if (req_i && cmd_i == ladp_pkg::CMD_TICK) begin
      sum_d = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      miss_q  <= '0;
      sum_q   <= '0;
      avg_q   <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      miss_q  <= miss_d;
      sum_q   <= sum_d;
      avg_q   <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins) begin
      lines_q[free_idx] <= line_i;
    end
  end

  assign mean_wait_o = avg_q;

endmodule

FILE: src/ladp_table_ram.sv
// Delta table storage: one synchronous RAM, one read and one write port.
// Entries read as zero until first written. Depends on ladp_pkg.
module ladp_table_ram (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        re_i,
  input  logic [ladp_pkg::TAB_W-1:0]  raddr_i,
  output ladp_pkg::entry_t            rdata_o,
  input  logic                        we_i,
  input  logic [ladp_pkg::TAB_W-1:0]  waddr_i,
  input  ladp_pkg::entry_t            wdata_i
);

  ladp_pkg::entry_t                     mem [ladp_pkg::TABLE_ENTRIES];
  logic [ladp_pkg::TABLE_ENTRIES-1:0]   valid_q;
  ladp_pkg::entry_t                     rdata_q;
  logic                                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

FILE: src/ladp_entry_update.sv
// Two-stage update of one table entry: offset search, then delta learning
// and history push, or a fresh entry on a tag change. Depends on ladp_pkg.
module ladp_entry_update (
  input  logic                          clk_i,
  input  logic                          search_en_i,
  input  ladp_pkg::entry_t              entry_i,
  input  logic [7:0]                    tag_i,
  input  logic [7:0]                    off_i,
  input  logic [ladp_pkg::STAMP_W-1:0]  now_i,
  input  logic [15:0]                   mean_wait_i,
  output ladp_pkg::entry_t              entry_o
);

  localparam int NS = ladp_pkg::OFFSET_SLOTS;

  ladp_pkg::entry_t  e_q;
  ladp_pkg::search_t s_q, s_d;
  logic [NS-1:0]     qual;
  logic [ladp_pkg::SLOT_W-1:0] cur, idx, hit_idx;
  logic [ladp_pkg::STAMP_W-1:0] age;

  // stage 1: find newest older offset past the average delay
  always_comb begin
    cur = entry_i.write_slot;
    for (int i = 0; i < NS; i++) begin
      age     = now_i - entry_i.stamps[i];
      qual[i] = (entry_i.stamps[i] != '0) && (now_i > entry_i.stamps[i])
                && (age > mean_wait_i);
    end
    s_d.same_page = (tag_i == entry_i.tag);
    s_d.no_change = s_d.same_page && (off_i == entry_i.offsets[cur]);
    s_d.found = 1'b0;
    hit_idx   = '0;
    for (int k = NS - 1; k >= 1; k--) begin
      idx = (cur >= ladp_pkg::SLOT_W'(k)) ? cur - ladp_pkg::SLOT_W'(k)
                                          : ladp_pkg::SLOT_W'(NS - k) + cur;
      if (qual[idx]) begin
        s_d.found = 1'b1;
        hit_idx   = idx;
      end
    end
    s_d.delta     = {1'b0, off_i} - {1'b0, entry_i.offsets[hit_idx]};
    s_d.peak_conf = '0;
    s_d.max_idx   = '0;
    for (int j = 0; j < ladp_pkg::DELTA_SLOTS; j++) begin
      if (entry_i.confs[j] > s_d.peak_conf) begin
        s_d.peak_conf = entry_i.confs[j];
        s_d.max_idx   = ladp_pkg::DSLOT_W'(j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (search_en_i) begin
      e_q <= entry_i;
      s_q <= s_d;
    end
  end

  // stage 2: learn the delta and push the new offset, or start a fresh entry on a new page
  logic                          matched, placed;
  logic [ladp_pkg::SLOT_W-1:0]   ws;

  always_comb begin
    entry_o = e_q;
    matched = 1'b0;
    placed  = 1'b0;
    ws      = e_q.write_slot;
    if (s_q.same_page) begin
      if (!s_q.no_change) begin
        if (s_q.found) begin
          for (int j = 0; j < ladp_pkg::DELTA_SLOTS; j++) begin
            if (!matched && e_q.deltas[j] == s_q.delta) begin
              matched = 1'b1;
              if (e_q.confs[j] < ladp_pkg::CONF_MAX) begin
                entry_o.confs[j] = e_q.confs[j] + 1'b1;
              end
            end
          end
          for (int j = 0; j < ladp_pkg::DELTA_SLOTS; j++) begin
            if (!matched && !placed && e_q.confs[j] == '0) begin
              placed = 1'b1;
              entry_o.deltas[j] = s_q.delta;
              entry_o.confs[j]  = 3'd1;
            end
          end
        end
        entry_o.offsets[ws] = off_i;
        entry_o.stamps[ws]  = now_i;
        entry_o.write_slot  = (ws == ladp_pkg::SLOT_W'(NS - 1)) ? '0 : ws + 1'b1;
      end
    end else begin
      entry_o = '0;
      entry_o.top_delta  = (s_q.peak_conf > ladp_pkg::CONF_THRESH)
                           ? e_q.deltas[s_q.max_idx] : e_q.top_delta;
      entry_o.tag        = tag_i;
      entry_o.offsets[0] = off_i;
      entry_o.stamps[0]  = now_i;
      entry_o.write_slot = (NS == 1) ? '0 : ladp_pkg::SLOT_W'(1);
    end
  end

endmodule

FILE: src/latency_aware_delta_prefetcher_unit.sv
// Top level of the latency aware delta prefetcher: request sequencer and
// result register. Depends on ladp_pkg, ladp_miss_track, ladp_table_ram,
// ladp_entry_update.
//
//  port group   dir  contents
//  s_axis_*     in   requests: tuser command, tdata address/was_hit/select/stamp
//  m_axis_*     out  results: tdata prefetch_valid/prefetch_address/entry_echo
//  cfg_*        in   start delay write
//
// Every request passes through table read and offset search; access commands
// then learn and write back through the single RAM port pair.
// One request is in flight at a time; the next is accepted once the result
// leaves the sequencer, even if the result register is still held.
// A stalled result register holds the sequencer in its write-back step.
// Reset clears the pending set, counters and the table valid bits at once.
module latency_aware_delta_prefetcher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // address[47:0], was_hit[48], entry_select[54:49],
                                       // cycle_stamp[70:55], zero pad
  input  logic [1:0]  s_axis_tuser_i,  // command[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // prefetch_valid[0], prefetch_address[48:1],
                                       // entry_echo[54:49], zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_WRITE  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept, out_free, finish;

  logic [1:0]                         cmd_q;
  logic [ladp_pkg::ADDR_W-1:0]        addr_q;
  logic [ladp_pkg::SEL_W-1:0]         sel_q;
  logic [ladp_pkg::STAMP_W-1:0]       now_q;

  logic                               out_valid_q;
  logic                               pf_valid_q;
  logic [ladp_pkg::ADDR_W-1:0]        pf_addr_q;
  logic [ladp_pkg::SEL_W-1:0]         echo_q;

  logic [15:0]        mean_wait;
  ladp_pkg::entry_t   rd_entry, new_entry;
  logic [ladp_pkg::ADDR_W-1:0] pf_addr;
  logic               is_access;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign finish   = (state_q == ST_WRITE) && out_free;
  assign is_access = (cmd_q == ladp_pkg::CMD_ACCESS);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_SEARCH;
      ST_SEARCH: state_d = ST_WRITE;
      ST_WRITE:  if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_axis_tuser_i;
      addr_q <= s_axis_tdata_i[47:0];
      sel_q  <= s_axis_tdata_i[54:49];
      now_q  <= s_axis_tdata_i[70:55];
    end
    if (finish) begin
      pf_valid_q <= is_access && (new_entry.top_delta != '0);
      pf_addr_q  <= (is_access && new_entry.top_delta != '0) ? pf_addr : '0;
      echo_q     <= (is_access || cmd_q == ladp_pkg::CMD_FILL) ? sel_q : '0;
    end
  end

  // best delta is in blocks of 64 bytes
  assign pf_addr = addr_q + {{(ladp_pkg::ADDR_W - 15){new_entry.top_delta[8]}},
                             new_entry.top_delta, 6'b0};

  ladp_miss_track u_miss (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (accept),
    .cmd_i       (s_axis_tuser_i),
    .was_hit_i   (s_axis_tdata_i[48]),
    .line_i      (s_axis_tdata_i[47:6]),
    .mean_wait_o (mean_wait)
  );

  ladp_table_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (s_axis_tdata_i[49 +: ladp_pkg::TAB_W]),
    .rdata_o (rd_entry),
    .we_i    (finish && is_access),
    .waddr_i (sel_q[ladp_pkg::TAB_W-1:0]),
    .wdata_i (new_entry)
  );

  ladp_entry_update u_upd (
    .clk_i       (clk_i),
    .search_en_i (state_q == ST_SEARCH),
    .entry_i     (rd_entry),
    .tag_i       (addr_q[19:12]),
    .off_i       (addr_q[13:6]),
    .now_i       (now_q),
    .mean_wait_i (mean_wait),
    .entry_o     (new_entry)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, echo_q, pf_addr_q, pf_valid_q};

endmodule
